// ===== hdl/tlpm_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpm_pkg
// Shared types and codes for the two-level page table mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpm_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  localparam int PPN_W  = 20;
  localparam int VPN_W  = 20;
  localparam int ADDR_W = 32;
  localparam int FLAG_W = 12;
  localparam int END_W  = 21;
  localparam int CFG_DATA_W = 21;
  localparam int CFG_IDX_W  = 3;

  localparam logic [1:0] KIND_ZERO = 2'd0;
  localparam logic [1:0] KIND_WORD = 2'd1;
  localparam logic [1:0] KIND_FULL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_TABLE_PAGE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_FIRST_PAGE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_END_PAGE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAF_FLAG_BITS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTER_FLAG_BITS = 3'd4;

  localparam logic [FLAG_W-1:0] LEAF_FLAGS_RESET    = 12'd47;
  localparam logic [FLAG_W-1:0] POINTER_FLAGS_RESET = 12'd1;

  typedef struct packed {
    logic             valid;
    logic [PPN_W-1:0] page;
  } shadow_entry_t;

  typedef struct packed {
    logic [PPN_W-1:0]  root_table_page;
    logic [PPN_W-1:0]  free_first_page;
    logic [END_W-1:0]  free_end_page;
    logic [FLAG_W-1:0] leaf_flag_bits;
    logic [FLAG_W-1:0] pointer_flag_bits;
  } cfg_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    shadow_entry_t    wr_data;
  } shd_req_t;

  typedef struct packed {
    logic clearing;
    logic alloc;
  } tlpm_stat_t;

endpackage

`default_nettype wire

// ===== hdl/tlpm_if.sv =====
// ----------------------------------------------------------------------------
// tlpm_if
// Valid/ready channels for mapping requests and memory write results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlpm_item_if import tlpm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VPN_W-1:0] virt_page;
  logic [PPN_W-1:0] phys_page;
  logic             range_end;

  modport source (output valid, virt_page, phys_page, range_end, input ready);
  modport sink   (input valid, virt_page, phys_page, range_end, output ready);
endinterface

interface tlpm_result_if import tlpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [ADDR_W-1:0] mem_address;
  logic [ADDR_W-1:0] mem_data;
  logic              last;
  logic              range_done;

  modport source (output valid, kind, mem_address, mem_data, last, range_done,
                  input ready);
  modport sink   (input valid, kind, mem_address, mem_data, last, range_done,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/tlpm_shadow_ram.sv =====
// ----------------------------------------------------------------------------
// tlpm_shadow_ram
// Root-entry shadow: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpm_shadow_ram
  import tlpm_pkg::*;
(
  input  wire logic          clk,
  input  wire shd_req_t      req,
  output shadow_entry_t      rdata
);

  shadow_entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tlpm_seq.sv =====
// ----------------------------------------------------------------------------
// tlpm_seq
// Sequencer: clears the shadow, looks up the root entry, allocates a
// table page and emits the result transactions through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpm_seq
  import tlpm_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cfg_t          cfg,
  tlpm_item_if.sink          item,
  tlpm_result_if.source      result,
  output shd_req_t           shd_req,
  input  wire shadow_entry_t shd_rdata,
  output tlpm_stat_t         stat
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic [1:0] MODE_HIT   = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_FULL  = 2'd2;

  logic [1:0]        state;
  logic [IDX_W-1:0]  clr_cnt;
  logic [END_W-1:0]  pages_allocated;
  logic [IDX_W-1:0]  hi;
  logic [IDX_W-1:0]  lo;
  logic [PPN_W-1:0]  ppn;
  logic              done;
  logic [1:0]        mode;
  logic [PPN_W-1:0]  tpage;
  logic [1:0]        step;

  logic              out_valid;
  logic [1:0]        out_kind;
  logic [ADDR_W-1:0] out_address;
  logic [ADDR_W-1:0] out_data;
  logic              out_last;
  logic              out_done;

  logic              accept;
  logic [END_W:0]    next_sum;
  logic              full;
  logic              hit;
  logic              out_load;
  logic              final_step;
  logic [1:0]        res_kind;
  logic [ADDR_W-1:0] res_address;
  logic [ADDR_W-1:0] res_data;
  logic [ADDR_W-1:0] leaf_data;

  assign accept   = item.valid && item.ready;
  assign next_sum = {2'b00, cfg.free_first_page} + {1'b0, pages_allocated};
  assign full     = (next_sum >= {1'b0, cfg.free_end_page}) ||
                    (next_sum[END_W:PPN_W] != 2'b00);
  assign hit      = shd_rdata.valid;
  assign out_load = (state == ST_EMIT) && (!out_valid || result.ready);
  assign final_step = (mode != MODE_ALLOC) || (step == 2'd2);
  assign leaf_data  = {ppn, {FLAG_W{1'b0}}} | {{PPN_W{1'b0}}, cfg.leaf_flag_bits};

  assign item.ready = (state == ST_IDLE);

  assign stat.clearing = (state == ST_CLEAR);
  assign stat.alloc    = (state == ST_LOOK) && !hit && !full;

  always_comb begin
    shd_req.rd_en   = accept;
    shd_req.rd_addr = item.virt_page[VPN_W-1:IDX_W];
    shd_req.wr_en   = 1'b0;
    shd_req.wr_addr = hi;
    shd_req.wr_data = '0;
    if (state == ST_CLEAR) begin
      shd_req.wr_en   = 1'b1;
      shd_req.wr_addr = clr_cnt;
    end else if (stat.alloc) begin
      shd_req.wr_en         = 1'b1;
      shd_req.wr_data.valid = cfg.pointer_flag_bits[0];
      shd_req.wr_data.page  = next_sum[PPN_W-1:0];
    end
  end

  always_comb begin
    res_kind    = KIND_WORD;
    res_address = {tpage, lo, 2'b00};
    res_data    = leaf_data;
    unique case (mode)
      MODE_HIT: begin
      end
      MODE_FULL: begin
        res_kind    = KIND_FULL;
        res_address = '0;
        res_data    = '0;
      end
      MODE_ALLOC: begin
        if (step == 2'd0) begin
          res_kind    = KIND_ZERO;
          res_address = {tpage, {FLAG_W{1'b0}}};
          res_data    = '0;
        end else if (step == 2'd1) begin
          res_address = {cfg.root_table_page, hi, 2'b00};
          res_data    = {tpage, cfg.pointer_flag_bits};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_cnt         <= '0;
      pages_allocated <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == IDX_W'(TABLE_ENTRIES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (stat.alloc) begin
            pages_allocated <= pages_allocated + 1'b1;
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load && final_step) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hi   <= item.virt_page[VPN_W-1:IDX_W];
      lo   <= item.virt_page[IDX_W-1:0];
      ppn  <= item.phys_page;
      done <= item.range_end;
    end
    if (state == ST_LOOK) begin
      step <= 2'd0;
      if (hit) begin
        mode  <= MODE_HIT;
        tpage <= shd_rdata.page;
      end else if (full) begin
        mode  <= MODE_FULL;
        tpage <= next_sum[PPN_W-1:0];
      end else begin
        mode  <= MODE_ALLOC;
        tpage <= next_sum[PPN_W-1:0];
      end
    end else if (out_load) begin
      step <= step + 1'b1;
    end
    if (out_load) begin
      out_kind    <= res_kind;
      out_address <= res_address;
      out_data    <= res_data;
      out_last    <= final_step;
      out_done    <= final_step && done;
    end
  end

  assign result.valid       = out_valid;
  assign result.kind        = out_kind;
  assign result.mem_address = out_address;
  assign result.mem_data    = out_data;
  assign result.last        = out_last;
  assign result.range_done  = out_done;

endmodule

`default_nettype wire

// ===== hdl/two_level_page_table_mapper_top.sv =====
// ----------------------------------------------------------------------------
// two_level_page_table_mapper_top
// Sv32-style page table entry writer with a root-entry shadow and a bump
// allocator for second-level table pages.
// ----------------------------------------------------------------------------
// After reset the block clears the root shadow RAM and accepts no mapping
// until that pass is over; configuration writes are taken at any time.
// Mappings are handled one at a time: a mapping whose root entry is valid,
// and one that finds the allocator exhausted, produces one result; one that
// allocates a table page produces three results. Each mapping passes through
// the shadow RAM's registered read and a lookup state, then emits one result
// per cycle into the output register while the output is not stalled.
// The next mapping is accepted while the final result still waits to be taken.
`default_nettype none

module two_level_page_table_mapper_top
  import tlpm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  tlpm_item_if.sink                  item,
  tlpm_result_if.source              result
);

  cfg_t          cfg;
  shd_req_t      shd_req;
  shadow_entry_t shd_rdata;
  tlpm_stat_t    stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.root_table_page   <= '0;
      cfg.free_first_page   <= '0;
      cfg.free_end_page     <= '0;
      cfg.leaf_flag_bits    <= LEAF_FLAGS_RESET;
      cfg.pointer_flag_bits <= POINTER_FLAGS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROOT_TABLE_PAGE:   cfg.root_table_page   <= cfg_data[PPN_W-1:0];
        CFG_FREE_FIRST_PAGE:   cfg.free_first_page   <= cfg_data[PPN_W-1:0];
        CFG_FREE_END_PAGE:     cfg.free_end_page     <= cfg_data[END_W-1:0];
        CFG_LEAF_FLAG_BITS:    cfg.leaf_flag_bits    <= cfg_data[FLAG_W-1:0];
        CFG_POINTER_FLAG_BITS: cfg.pointer_flag_bits <= cfg_data[FLAG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tlpm_shadow_ram u_ram (
    .clk   (clk),
    .req   (shd_req),
    .rdata (shd_rdata)
  );

  tlpm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (item),
    .result    (result),
    .shd_req   (shd_req),
    .shd_rdata (shd_rdata),
    .stat      (stat)
  );

  // no mapping enters during the shadow clearing pass
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |-> !stat.clearing)
    else $error("mapping accepted during shadow clear");

  // one mapping at a time
  a_interlock: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("second mapping accepted during lookup");

  // an allocation claims a shadow write at the same cycle
  a_alloc_writes: assert property (@(posedge clk) disable iff (rst)
    stat.alloc |-> (shd_req.wr_en && !stat.clearing))
    else $error("allocation without shadow write");

  // error results always close the transaction sequence of their mapping
  a_full_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind == KIND_FULL) |->
      (result.last && result.mem_address == '0 && result.mem_data == '0))
    else $error("malformed exhaustion result");

endmodule

`default_nettype wire

// ===== tb/map_check_pkg.sv =====
// ----------------------------------------------------------------------------
// map_check_pkg
// Write predictor and scoreboard for the two-level page table mapper. It keeps
// its own copy of the root shadow, the page allocator and the registers. From
// each accepted mapping it works out the memory writes that must follow, and
// it checks them in order against the result channel.
// ----------------------------------------------------------------------------
package map_check_pkg;
  import tlpm_pkg::*;

  localparam int NEXT_W = END_W + 1;
  localparam logic [PPN_W-1:0] PPN_TOP = {PPN_W{1'b1}};

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] mem_address;
    logic [ADDR_W-1:0] mem_data;
    logic              last;
    logic              range_done;
  } mem_write_t;

  class map_scoreboard;
    cfg_t             regs;
    shadow_entry_t    root_shadow [TABLE_ENTRIES];
    logic [END_W-1:0] pages_allocated;
    mem_write_t       pending_writes [$];
    int               errors;
    int               n_maps;
    int               n_writes;
    int               n_allocs;
    int               n_hits;
    int               n_full;

    function new();
      regs.root_table_page   = '0;
      regs.free_first_page   = '0;
      regs.free_end_page     = '0;
      regs.leaf_flag_bits    = LEAF_FLAGS_RESET;
      regs.pointer_flag_bits = POINTER_FLAGS_RESET;
      foreach (root_shadow[i]) root_shadow[i] = '0;
      pages_allocated = '0;
      errors   = 0;
      n_maps   = 0;
      n_writes = 0;
      n_allocs = 0;
      n_hits   = 0;
      n_full   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ROOT_TABLE_PAGE:   regs.root_table_page   = data[PPN_W-1:0];
        CFG_FREE_FIRST_PAGE:   regs.free_first_page   = data[PPN_W-1:0];
        CFG_FREE_END_PAGE:     regs.free_end_page     = data[END_W-1:0];
        CFG_LEAF_FLAG_BITS:    regs.leaf_flag_bits    = data[FLAG_W-1:0];
        CFG_POINTER_FLAG_BITS: regs.pointer_flag_bits = data[FLAG_W-1:0];
        default: ;
      endcase
    endfunction

    function void add_write(logic [1:0] kind, logic [ADDR_W-1:0] addr,
                            logic [ADDR_W-1:0] data, logic last, logic done);
      mem_write_t w;
      w.kind        = kind;
      w.mem_address = addr;
      w.mem_data    = data;
      w.last        = last;
      w.range_done  = done;
      pending_writes.push_back(w);
    endfunction

    // one accepted mapping transaction
    function void map_page(logic [VPN_W-1:0] vpn, logic [PPN_W-1:0] ppn, logic re);
      logic [IDX_W-1:0]  hi;
      logic [IDX_W-1:0]  lo;
      logic [ADDR_W-1:0] leaf;
      logic [NEXT_W-1:0] next_page;
      hi   = vpn[VPN_W-1:IDX_W];
      lo   = vpn[IDX_W-1:0];
      leaf = {ppn, regs.leaf_flag_bits};
      n_maps++;
      if (root_shadow[hi].valid) begin
        n_hits++;
        add_write(KIND_WORD, {root_shadow[hi].page, lo, 2'b00}, leaf, 1'b1, re);
        return;
      end
      next_page = NEXT_W'(regs.free_first_page) + NEXT_W'(pages_allocated);
      if (next_page >= NEXT_W'(regs.free_end_page) || next_page > NEXT_W'(PPN_TOP)) begin
        n_full++;
        add_write(KIND_FULL, '0, '0, 1'b1, re);
        return;
      end
      n_allocs++;
      pages_allocated = pages_allocated + 1'b1;
      root_shadow[hi].valid = regs.pointer_flag_bits[0];
      root_shadow[hi].page  = next_page[PPN_W-1:0];
      add_write(KIND_ZERO, {next_page[PPN_W-1:0], 12'h000}, '0, 1'b0, 1'b0);
      add_write(KIND_WORD, {regs.root_table_page, hi, 2'b00},
                {next_page[PPN_W-1:0], regs.pointer_flag_bits}, 1'b0, 1'b0);
      add_write(KIND_WORD, {next_page[PPN_W-1:0], lo, 2'b00}, leaf, 1'b1, re);
    endfunction

    task report(string what);
      // keep the log short when everything goes wrong
      if (errors < 40) $display("MISMATCH %s", what);
      errors++;
    endtask

    task check_write(mem_write_t got);
      mem_write_t want;
      n_writes++;
      if (pending_writes.size() == 0) begin
        report($sformatf("write %0d: none pending, got kind %0d addr %h data %h",
                         n_writes, got.kind, got.mem_address, got.mem_data));
        return;
      end
      want = pending_writes.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("write %0d kind: got %0d want %0d", n_writes, got.kind, want.kind));
      if (got.mem_address !== want.mem_address)
        report($sformatf("write %0d mem_address: got %h want %h", n_writes,
                         got.mem_address, want.mem_address));
      if (got.mem_data !== want.mem_data)
        report($sformatf("write %0d mem_data: got %h want %h", n_writes,
                         got.mem_data, want.mem_data));
      if (got.last !== want.last)
        report($sformatf("write %0d last: got %b want %b", n_writes, got.last, want.last));
      if (got.range_done !== want.range_done)
        report($sformatf("write %0d range_done: got %b want %b", n_writes,
                         got.range_done, want.range_done));
    endtask
  endclass

endpackage

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the two-level page table mapper. A directed part covers the
// exhausted allocator straight after reset, root hits and allocations at the
// field extremes, a clear root valid bit, the top physical page, and a next
// page past 20 bits. Random phases then run mappings on several register
// settings, with random gaps and stalls on both channels in all but one phase.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tlpm_pkg::*;
  import map_check_pkg::*;

  localparam int RUN_LIMIT  = 200000;
  localparam int POOL_SIZE  = 24;
  localparam int PHASE_MAPS = 70;
  localparam int PPN_MAX    = 32'h000F_FFFF;
  localparam int END_MAX    = 32'h001F_FFFF;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  no_idle = 1'b0;
  int                    cycles = 0;
  logic [IDX_W-1:0]      hi_pool [POOL_SIZE];
  mem_write_t            seen_write;

  map_scoreboard sb = new();

  tlpm_item_if   item_ch ();
  tlpm_result_if result_ch ();

  two_level_page_table_mapper_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  always begin
    clk = 1'b0;
    #10ns;
    clk = 1'b1;
    #10ns;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= no_idle || ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      seen_write.kind        = result_ch.kind;
      seen_write.mem_address = result_ch.mem_address;
      seen_write.mem_data    = result_ch.mem_data;
      seen_write.last        = result_ch.last;
      seen_write.range_done  = result_ch.range_done;
      sb.check_write(seen_write);
    end
  end

  task automatic send_map(input logic [VPN_W-1:0] vpn, input logic [PPN_W-1:0] ppn,
                          input logic re);
    while (!no_idle && $urandom_range(99) < 27) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.virt_page <= vpn;
    item_ch.phys_page <= ppn;
    item_ch.range_end <= re;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    sb.map_page(vpn, ppn, re);
  endtask

  task automatic random_map();
    logic [IDX_W-1:0] hi;
    if ($urandom_range(99) < 80) hi = hi_pool[$urandom_range(POOL_SIZE - 1)];
    else hi = IDX_W'($urandom);
    send_map({hi, IDX_W'($urandom)}, PPN_W'($urandom), 1'($urandom));
  endtask

  // hold the sender until every write has come back, then let the block settle
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (sb.pending_writes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_regs(input int unsigned root_pg, first_pg, end_pg, leaf, ptr);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    idx = '{CFG_ROOT_TABLE_PAGE, CFG_FREE_FIRST_PAGE, CFG_FREE_END_PAGE,
            CFG_LEAF_FLAG_BITS, CFG_POINTER_FLAG_BITS};
    val = '{CFG_DATA_W'(root_pg), CFG_DATA_W'(first_pg), CFG_DATA_W'(end_pg),
            CFG_DATA_W'(leaf), CFG_DATA_W'(ptr)};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // next free page lands at a random base with room for the given page count
  task automatic open_window(input int unsigned width, root_pg, leaf, ptr);
    int unsigned base;
    base = $urandom_range(PPN_MAX - width, sb.pages_allocated);
    load_regs(root_pg, base - sb.pages_allocated, base + width, leaf, ptr);
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = CFG_ROOT_TABLE_PAGE;
    cfg_data          = '0;
    item_ch.valid     = 1'b0;
    item_ch.virt_page = '0;
    item_ch.phys_page = '0;
    item_ch.range_end = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings leave no free page
    send_map('0, '0, 1'b0);
    send_map('1, '1, 1'b1);
    wait_idle();

    load_regs(PPN_MAX, 0, 16, 12'hFFF, 12'h001);
    send_map(20'h00000, 20'hFFFFF, 1'b1);
    send_map(20'h003FF, 20'h00000, 1'b0);
    send_map(20'hFFFFF, 20'h5A5A5, 1'b1);
    send_map(20'hFFC00, 20'hFFFFF, 1'b0);
    wait_idle();

    // root valid bit clear: same root entry allocates up to the top page
    load_regs(0, PPN_MAX - 2 - sb.pages_allocated, 32'h0010_0000, 12'h000, 12'hFFE);
    send_map(20'h01401, 20'h12345, 1'b0);
    send_map(20'h01402, 20'hEDCBA, 1'b1);
    send_map(20'h017FF, 20'h00001, 1'b0);
    send_map(20'h01400, 20'h80000, 1'b1);
    wait_idle();

    // next page past 20 bits while still below the end register
    load_regs(20'hABCDE, PPN_MAX - sb.pages_allocated, END_MAX, 12'h555, 12'hFFF);
    send_map(20'h01C00, 20'h0F0F0, 1'b1);
    send_map(20'h02400, 20'hF0F0F, 1'b0);
    send_map(20'h01FFF, 20'h33333, 1'b1);
    wait_idle();

    // end page equal to the next page
    load_regs(20'h12345, 0, sb.pages_allocated, 12'hAAA, 12'h001);
    send_map(20'hAA800, 20'h11111, 1'b0);
    send_map(20'h00155, 20'h22222, 1'b1);

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      foreach (hi_pool[i]) hi_pool[i] = IDX_W'($urandom);
      case (p)
        0: open_window(48, $urandom_range(PPN_MAX), $urandom_range(4095),
                       $urandom_range(4095) | 1);
        1: open_window(100, $urandom_range(PPN_MAX), $urandom_range(4095),
                       $urandom_range(4095) & 12'hFFE);
        2: open_window(40, $urandom_range(PPN_MAX), $urandom_range(4095),
                       $urandom_range(4095) | 1);
        3: load_regs(PPN_MAX, PPN_MAX - 20 - sb.pages_allocated, END_MAX,
                     $urandom_range(4095), 12'hFFF);
        4: load_regs($urandom_range(PPN_MAX), $urandom_range(PPN_MAX),
                     $urandom_range(END_MAX), $urandom_range(4095),
                     $urandom_range(4095));
        default: open_window(64, 0, 12'h000, 12'h001);
      endcase
      no_idle <= (p == 1);
      for (int n = 0; n < PHASE_MAPS; n++) random_map();
    end
    wait_idle();
    no_idle <= 1'b0;

    $display("Mapped %0d pages: %0d table allocations, %0d root hits, %0d out of pages",
             sb.n_maps, sb.n_allocs, sb.n_hits, sb.n_full);
    $display("Checked %0d memory writes, %0d mismatches", sb.n_writes, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
